>>> rtl/clcd_pkg.sv
package clcd_pkg;

    // configuration register widths
    localparam int PWR_W     = 14;
    localparam int FIRST_W   = 13;
    localparam int SECOND_W  = 10;
    localparam int SETTLE_W  = 8;
    localparam int DELAY_W   = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 14;

    // payload widths
    localparam int MODE_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int STEP_W    = 4;
    localparam int PHASE_W   = 4;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PWR_WAIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WAIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK       = 3'd5;

    // register reset values
    localparam logic [PWR_W-1:0]    RST_PWR_WAIT    = 14'd15000;
    localparam logic [FIRST_W-1:0]  RST_FIRST_WAIT  = 13'd5000;
    localparam logic [SECOND_W-1:0] RST_SECOND_WAIT = 10'd150;
    localparam logic [SETTLE_W-1:0] RST_SETTLE      = 8'd100;

    // request modes
    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WR_INSTR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WR_DATA   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RD_ADDR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RD_DATA   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INIT      = 3'd5;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PWR   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_P_LO  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_P_HI  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_P_SET = 4'd4;
    localparam logic [PHASE_W-1:0] PH_GAP   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_Q_HI1 = 4'd6;
    localparam logic [PHASE_W-1:0] PH_Q_LO  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_Q_HI2 = 4'd8;
    localparam logic [PHASE_W-1:0] PH_Q_SET = 4'd9;
    localparam logic [PHASE_W-1:0] PH_R_HI1 = 4'd10;
    localparam logic [PHASE_W-1:0] PH_R_LO  = 4'd11;
    localparam logic [PHASE_W-1:0] PH_R_HI2 = 4'd12;
    localparam logic [PHASE_W-1:0] PH_R_SET = 4'd13;

    // init sequence constants
    localparam logic [STEP_W-1:0] STEP_LAST_RAW = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DISP_ON  = 4'd8;
    localparam logic [BYTE_W-1:0] NIB_FUNC8     = 8'h03;
    localparam logic [BYTE_W-1:0] NIB_FUNC4     = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [BYTE_W-1:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_DISP_ON   = 8'h0C;

    // pin levels, packed as rs in bit 0 up to drive in bit 7
    typedef struct packed {
        logic             drive;
        logic [NIB_W-1:0] bus;
        logic             en;
        logic             rw;
        logic             rs;
    } t_lines;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  value;
    } t_init_next;

    function automatic logic [BYTE_W-1:0] f_init_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = CMD_FUNC_SET;
            2'd1:    b = CMD_DISP_OFF;
            2'd2:    b = CMD_CLEAR;
            default: b = CMD_ENTRY;
        endcase
        return b;
    endfunction

    // phase and byte for one init step; past the last step the sequence ends
    function automatic t_init_next f_init_item(input logic [STEP_W-1:0] step,
                                               input logic [BYTE_W-1:0] cur,
                                               input logic cursor,
                                               input logic blink);
        t_init_next r;
        r.phase = PH_P_LO;
        r.value = cur;
        if (step < 4'd4) begin
            r.value = (step == STEP_LAST_RAW) ? NIB_FUNC4 : NIB_FUNC8;
        end else if (step < STEP_DISP_ON) begin
            r.value = f_init_byte(step[1:0]);
        end else if (step == STEP_DISP_ON) begin
            r.value = CMD_DISP_ON | {6'd0, cursor, blink};
        end else begin
            r.phase = PH_IDLE;
        end
        return r;
    endfunction

endpackage

>>> rtl/char_lcd_4bit_bus_sequencer_core.sv
// channel  | signals                          | contents
// ---------+----------------------------------+-----------------------------------------
// s (in)   | i_s_tvalid/o_s_tready/tdata/tuser | one microsecond tick, mode, byte, bus
// m (out)  | o_m_tvalid/i_m_tready/tdata       | pin levels, ready flag, read byte
// cfg      | i_cfg_we/i_cfg_index/i_cfg_data   | register writes, no read-back
//
// one request per clock while m takes each result: the sequencer state and the result register
// advance together on each accepted tick, so the result appears in the cycle after its request
// the result register frees itself when taken, so s accepts in the same cycle that m
// is emptied; only a held result on m stalls s
// reset is synchronous, active low; it clears the sequencer and reloads the registers
module char_lcd_4bit_bus_sequencer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // value[7:0], bus_in[11:8], zero fill [15:12]
    input  logic [clcd_pkg::S_DATA_W-1:0]  i_s_tdata,
    // mode[2:0]
    input  logic [clcd_pkg::MODE_W-1:0]    i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // rs_line[0], rw_line[1], en_line[2], bus_out[6:3], bus_drive[7], ready_res[8],
    // read_data[16:9], read_valid[17], zero fill [23:18]
    output logic [clcd_pkg::M_DATA_W-1:0]  o_m_tdata,
    input  logic                           i_cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [clcd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import clcd_pkg::*;

    // configuration registers
    logic [PWR_W-1:0]    r_pwr_wait;
    logic [FIRST_W-1:0]  r_first_wait;
    logic [SECOND_W-1:0] r_second_wait;
    logic [SETTLE_W-1:0] r_settle;
    logic                r_cursor;
    logic                r_blink;

    // sequencer state
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_nib_idx, n_nib_idx;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [BYTE_W-1:0]   r_value, n_value;
    logic [BYTE_W-1:0]   r_capt, n_capt;
    t_lines              r_lines, n_lines;

    // result register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic                s_req;
    logic                ready;
    logic                rv;
    logic                rs;
    logic                rs_rd;
    logic                raw;
    logic                done;
    logic [NIB_W-1:0]    nib;
    logic [DELAY_W-1:0]  settle_ticks;
    logic [MODE_W-1:0]   in_mode;
    logic [BYTE_W-1:0]   in_value;
    logic [NIB_W-1:0]    in_bus;
    t_init_next          init_nx;

    assign in_mode  = i_s_tuser;
    assign in_value = i_s_tdata[BYTE_W-1:0];
    assign in_bus   = i_s_tdata[BYTE_W+NIB_W-1:BYTE_W];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_req      = i_s_tvalid && o_s_tready;
    assign settle_ticks = (r_settle == '0) ? DELAY_W'(1) : DELAY_W'(r_settle);

    // next state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_delay   = r_delay;
        n_step    = r_step;
        n_nib_idx = r_nib_idx;
        n_mode    = r_mode;
        n_value   = r_value;
        n_capt    = r_capt;
        n_lines   = r_lines;
        rv        = 1'b0;
        done      = 1'b0;
        init_nx   = f_init_item(r_step, r_value, r_cursor, r_blink);
        ready     = (r_phase == PH_IDLE);

        // take a new request while idle
        if (ready && in_mode >= MODE_WR_INSTR && in_mode <= MODE_INIT) begin
            n_mode    = in_mode;
            n_value   = in_value;
            n_nib_idx = 1'b0;
            n_capt    = '0;
            n_step    = '0;
            if (in_mode <= MODE_WR_DATA) begin
                n_phase = PH_P_LO;
            end else if (in_mode <= MODE_RD_DATA) begin
                n_phase = PH_R_HI1;
            end else if (r_pwr_wait == '0) begin
                init_nx = f_init_item(n_step, n_value, r_cursor, r_blink);
                n_phase = init_nx.phase;
                n_value = init_nx.value;
            end else begin
                n_delay = r_pwr_wait;
                n_phase = PH_PWR;
            end
        end

        rs    = (n_mode == MODE_WR_DATA);
        rs_rd = (n_mode == MODE_RD_DATA);
        raw   = (n_mode == MODE_INIT) && (n_step <= STEP_LAST_RAW);
        nib   = (raw || n_nib_idx) ? n_value[NIB_W-1:0] : n_value[BYTE_W-1:NIB_W];

        // pin timeline
        case (n_phase)
            PH_IDLE: begin
            end
            PH_PWR: begin
                n_lines = '0;
                if (n_delay <= DELAY_W'(1)) begin
                    n_delay   = '0;
                    n_nib_idx = 1'b0;
                    init_nx   = f_init_item(n_step, n_value, r_cursor, r_blink);
                    n_phase   = init_nx.phase;
                    n_value   = init_nx.value;
                end else begin
                    n_delay = n_delay - DELAY_W'(1);
                end
            end
            PH_P_LO: begin
                n_lines = '{drive: 1'b1, bus: nib, en: 1'b0, rw: 1'b0, rs: rs};
                n_phase = PH_P_HI;
            end
            PH_P_HI: begin
                n_lines = '{drive: 1'b1, bus: nib, en: 1'b1, rw: 1'b0, rs: rs};
                n_delay = settle_ticks;
                n_phase = PH_P_SET;
            end
            PH_P_SET: begin
                n_lines = '{drive: 1'b1, bus: nib, en: 1'b0, rw: 1'b0, rs: rs};
                if (n_delay <= DELAY_W'(1)) begin
                    n_delay = '0;
                    if (raw && n_step <= STEP_W'(1)) begin
                        // timed gap after the first two raw nibbles
                        done    = 1'b1;
                        n_delay = (n_step == '0) ? DELAY_W'(r_first_wait)
                                                 : DELAY_W'(r_second_wait);
                        if (n_delay != '0) begin
                            done    = 1'b0;
                            n_phase = PH_GAP;
                        end
                    end else if (raw) begin
                        n_phase = PH_Q_HI1;
                    end else if (!n_nib_idx) begin
                        n_nib_idx = 1'b1;
                        n_phase   = PH_P_LO;
                    end else begin
                        n_phase = PH_Q_HI1;
                    end
                end else begin
                    n_delay = n_delay - DELAY_W'(1);
                end
            end
            PH_GAP: begin
                n_lines.en = 1'b0;
                if (n_delay <= DELAY_W'(1)) begin
                    n_delay = '0;
                    done    = 1'b1;
                end else begin
                    n_delay = n_delay - DELAY_W'(1);
                end
            end
            PH_Q_HI1: begin
                n_lines   = '{drive: 1'b0, bus: '0, en: 1'b1, rw: 1'b1, rs: 1'b0};
                n_nib_idx = in_bus[NIB_W-1];
                n_phase   = PH_Q_LO;
            end
            PH_Q_LO: begin
                n_lines = '{drive: 1'b0, bus: '0, en: 1'b0, rw: 1'b1, rs: 1'b0};
                n_phase = PH_Q_HI2;
            end
            PH_Q_HI2: begin
                n_lines = '{drive: 1'b0, bus: '0, en: 1'b1, rw: 1'b1, rs: 1'b0};
                n_delay = settle_ticks;
                n_phase = PH_Q_SET;
            end
            PH_Q_SET: begin
                n_lines = '{drive: 1'b0, bus: '0, en: 1'b0, rw: 1'b1, rs: 1'b0};
                if (n_delay <= DELAY_W'(1)) begin
                    n_delay = '0;
                    if (n_nib_idx) begin
                        n_phase = PH_Q_HI1;
                    end else if (n_mode == MODE_INIT) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                        rv = (n_mode == MODE_RD_ADDR) || (n_mode == MODE_RD_DATA);
                    end
                end else begin
                    n_delay = n_delay - DELAY_W'(1);
                end
            end
            PH_R_HI1: begin
                n_lines = '{drive: 1'b0, bus: '0, en: 1'b1, rw: 1'b1, rs: rs_rd};
                n_capt  = rs_rd ? {in_bus, 4'd0} : {1'b0, in_bus[2:0], 4'd0};
                n_phase = PH_R_LO;
            end
            PH_R_LO: begin
                n_lines = '{drive: 1'b0, bus: '0, en: 1'b0, rw: 1'b1, rs: rs_rd};
                n_phase = PH_R_HI2;
            end
            PH_R_HI2: begin
                n_lines = '{drive: 1'b0, bus: '0, en: 1'b1, rw: 1'b1, rs: rs_rd};
                n_capt  = n_capt | {4'd0, in_bus};
                n_delay = settle_ticks;
                n_phase = PH_R_SET;
            end
            PH_R_SET: begin
                n_lines = '{drive: 1'b0, bus: '0, en: 1'b0, rw: 1'b1, rs: rs_rd};
                if (n_delay <= DELAY_W'(1)) begin
                    n_delay = '0;
                    n_phase = PH_Q_HI1;
                end else begin
                    n_delay = n_delay - DELAY_W'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // advance to the next init step after a gap, a skipped zero-length gap or a finished poll
        if (done) begin
            n_step    = n_step + STEP_W'(1);
            n_nib_idx = 1'b0;
            init_nx   = f_init_item(n_step, n_value, r_cursor, r_blink);
            n_phase   = init_nx.phase;
            n_value   = init_nx.value;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwr_wait    <= RST_PWR_WAIT;
            r_first_wait  <= RST_FIRST_WAIT;
            r_second_wait <= RST_SECOND_WAIT;
            r_settle      <= RST_SETTLE;
            r_cursor      <= 1'b1;
            r_blink       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PWR_WAIT:    r_pwr_wait    <= i_cfg_data[PWR_W-1:0];
                REG_FIRST_WAIT:  r_first_wait  <= i_cfg_data[FIRST_W-1:0];
                REG_SECOND_WAIT: r_second_wait <= i_cfg_data[SECOND_W-1:0];
                REG_SETTLE:      r_settle      <= i_cfg_data[SETTLE_W-1:0];
                REG_CURSOR:      r_cursor      <= i_cfg_data[0];
                REG_BLINK:       r_blink       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_delay   <= '0;
            r_step    <= '0;
            r_nib_idx <= 1'b0;
            r_mode    <= MODE_TICK;
            r_value   <= '0;
            r_capt    <= '0;
            r_lines   <= '0;
        end else if (s_req) begin
            r_phase   <= n_phase;
            r_delay   <= n_delay;
            r_step    <= n_step;
            r_nib_idx <= n_nib_idx;
            r_mode    <= n_mode;
            r_value   <= n_value;
            r_capt    <= n_capt;
            r_lines   <= n_lines;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_req) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_req) begin
            r_out_data <= {6'd0, rv, (rv ? n_capt : 8'd0), ready, n_lines};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // a read completes only on the released, enable-low tail of its poll
    a_read_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[17]) |->
        (r_out_data[1] && !r_out_data[2] && !r_out_data[7]))
        else $error("read completed with lines not in read tail");

    // the bus is never driven while the display is asked to drive it
    a_no_contention: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lines.drive |-> !r_lines.rw)
        else $error("bus driven during a read cycle");

    // the delay counter is drained whenever the sequencer is idle
    a_idle_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_delay == '0))
        else $error("delay counter left running while idle");

    // a result flagged ready comes from a tick taken while idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_req && r_phase != PH_IDLE) |=> !r_out_data[8])
        else $error("ready flag set on a busy tick");
`endif

endmodule
